FILE: rtl/core/erv_pkg.sv
// ----------------------------------------------------------------------------
// erv_pkg
// Types, constants and helpers for the Euler-angle vector rotation unit.
// ----------------------------------------------------------------------------
package erv_pkg;

   localparam int VALUE_W = 32;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ANGLE_W = 27;
   localparam int TRIG_W = 33;
   localparam int AW = VALUE_W + 3;
   localparam int PW = AW + TRIG_W;
   localparam int RW = VALUE_W + 1;

   localparam longint DEG_FULL = 360 * 65536;
   localparam longint DEG_HALF = 180 * 65536;
   localparam longint DEG_QUARTER = 90 * 65536;
   localparam logic [TRIG_W-1:0] CORDIC_GAIN = TRIG_W'(652032875);

   localparam logic OP_FORWARD = 1'b0;
   localparam logic OP_INVERSE = 1'b1;

   localparam logic [1:0] IDX_X = 2'd0;
   localparam logic [1:0] IDX_Y = 2'd1;
   localparam logic [1:0] IDX_Z = 2'd2;

   typedef struct packed {
      logic op;
      logic signed [VALUE_W-1:0] vec_x;
      logic signed [VALUE_W-1:0] vec_y;
      logic signed [VALUE_W-1:0] vec_z;
      logic signed [VALUE_W-1:0] angle_x;
      logic signed [VALUE_W-1:0] angle_y;
      logic signed [VALUE_W-1:0] angle_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] out_x;
      logic signed [VALUE_W-1:0] out_y;
      logic signed [VALUE_W-1:0] out_z;
   } rsp_payload_type;

   typedef struct packed {
      logic op;
      logic [2:0][VALUE_W-1:0] vec;
   } carry_type;

   // smallest k with full turn << k covering the signed input range
   function automatic int red_shift();
      int k;
      k = 0;
      for (int i = 0; i < 40; i++) begin
         if (DEG_FULL < ((longint'(1) << (VALUE_W - 1)) >>> i)) k = i + 1;
      end
      return k;
   endfunction

   localparam int RED_STEPS = red_shift();

   // atan(2^-i) in Q16.16 degrees
   function automatic logic [ANGLE_W-1:0] atan_deg(int i);
      logic [ANGLE_W-1:0] v;
      case (i)
         0: v = ANGLE_W'(2949120);
         1: v = ANGLE_W'(1740967);
         2: v = ANGLE_W'(919879);
         3: v = ANGLE_W'(466945);
         4: v = ANGLE_W'(234379);
         5: v = ANGLE_W'(117304);
         6: v = ANGLE_W'(58666);
         7: v = ANGLE_W'(29335);
         8: v = ANGLE_W'(14668);
         9: v = ANGLE_W'(7334);
         10: v = ANGLE_W'(3667);
         11: v = ANGLE_W'(1833);
         12: v = ANGLE_W'(917);
         13: v = ANGLE_W'(458);
         14: v = ANGLE_W'(229);
         15: v = ANGLE_W'(115);
         16: v = ANGLE_W'(57);
         17: v = ANGLE_W'(29);
         18: v = ANGLE_W'(14);
         19: v = ANGLE_W'(7);
         20: v = ANGLE_W'(4);
         21: v = ANGLE_W'(2);
         22: v = ANGLE_W'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

   // first component of the pair turned in rotation k
   function automatic logic [1:0] turn_a(logic op, int k);
      logic [1:0] r;
      case (k)
         0: r = (op == OP_INVERSE) ? IDX_Z : IDX_X;
         1: r = IDX_Y;
         default: r = (op == OP_INVERSE) ? IDX_X : IDX_Z;
      endcase
      return r;
   endfunction

   // second component of the pair turned in rotation k
   function automatic logic [1:0] turn_b(logic op, int k);
      logic [1:0] r;
      case (k)
         0: r = (op == OP_INVERSE) ? IDX_X : IDX_Y;
         1: r = IDX_Z;
         default: r = (op == OP_INVERSE) ? IDX_Y : IDX_X;
      endcase
      return r;
   endfunction

   // axis whose angle drives rotation k
   function automatic logic [1:0] turn_ang(logic op, int k);
      logic [1:0] r;
      case (k)
         0: r = (op == OP_INVERSE) ? IDX_Y : IDX_Z;
         1: r = IDX_X;
         default: r = (op == OP_INVERSE) ? IDX_Z : IDX_Y;
      endcase
      return r;
   endfunction

   // product with a q2.30 coefficient, rounded half up
   function automatic logic [AW-1:0] round_q30(logic [PW-1:0] p);
      logic signed [PW-1:0] t;
      t = ($signed(p) + $signed(PW'(1) << 29)) >>> 30;
      return AW'(t);
   endfunction

endpackage

FILE: rtl/core/euler_rotate_vector_unit.sv
// ----------------------------------------------------------------------------
// euler_rotate_vector_unit
// Rotates a Q16.16 vector by three Euler angles, Z-X-Y or inverse Y-X-Z.
// ----------------------------------------------------------------------------
// throughput: one transfer per cycle while no result is stalled; the angle
// reduction chain, one CORDIC stage per iteration and two stages per rotation
// set the depth
// a stalled result freezes the whole pipeline
// reset clears the valid bits only
module euler_rotate_vector_unit
   import erv_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   localparam int RS = RED_STEPS;
   localparam int N = CORDIC_STEPS;
   localparam logic [RW-1:0] RED_BIAS = RW'(DEG_FULL << RS);
   localparam logic [RW-1:0] R_QUARTER = RW'(DEG_QUARTER);
   localparam logic [RW-1:0] R_3QUARTER = RW'(3 * DEG_QUARTER);
   localparam logic [ANGLE_W-1:0] A_HALF = ANGLE_W'(DEG_HALF);
   localparam logic [ANGLE_W-1:0] A_FULL = ANGLE_W'(DEG_FULL);
   localparam logic signed [AW-1:0] SAT_MAX = AW'((longint'(1) << (VALUE_W - 1)) - 1);
   localparam logic signed [AW-1:0] SAT_MIN = -SAT_MAX - AW'(1);

   logic adv;
   logic rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;

   assign adv = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // angle reduction to [0, 360)
   logic [2:0][VALUE_W-1:0] ang_raw;
   logic [2:0][RW-1:0] pre_ang_in;
   logic [RS:0] red_vld_ff;
   carry_type red_car_ff [RS+1];
   logic [2:0][RW-1:0] red_ang_ff [RS+1];

   assign ang_raw = {req_payload.angle_z, req_payload.angle_y, req_payload.angle_x};

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         pre_ang_in[l] = {ang_raw[l][VALUE_W-1], ang_raw[l]}
            + (ang_raw[l][VALUE_W-1] ? RED_BIAS : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         red_vld_ff[0] <= req_valid;
      end
      if (adv) begin
         red_ang_ff[0] <= pre_ang_in;
         red_car_ff[0] <= {req_payload.op,
                           {req_payload.vec_z, req_payload.vec_y, req_payload.vec_x}};
      end
   end

   for (genvar j = 1; j <= RS; j++) begin : g_red
      localparam logic [RW-1:0] STEP = RW'(DEG_FULL << (RS - j));
      logic [2:0][RW-1:0] ang_in;
      always_comb begin
         for (int l = 0; l < 3; l++) begin
            ang_in[l] = (red_ang_ff[j-1][l] >= STEP) ? red_ang_ff[j-1][l] - STEP
                                                     : red_ang_ff[j-1][l];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            red_vld_ff[j] <= 1'b0;
         end else if (adv) begin
            red_vld_ff[j] <= red_vld_ff[j-1];
         end
         if (adv) begin
            red_ang_ff[j] <= ang_in;
            red_car_ff[j] <= red_car_ff[j-1];
         end
      end
   end

   // fold into [-90, 90] and load the cordic
   logic [N:0] cor_vld_ff;
   carry_type cor_car_ff [N+1];
   logic [2:0][TRIG_W-1:0] cor_x_ff [N+1];
   logic [2:0][TRIG_W-1:0] cor_y_ff [N+1];
   logic [2:0][ANGLE_W-1:0] cor_z_ff [N+1];
   logic [2:0] cor_neg_ff [N+1];
   logic [2:0][ANGLE_W-1:0] fld_z_in;
   logic [2:0] fld_neg_in;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (red_ang_ff[RS][l] <= R_QUARTER) begin
            fld_z_in[l] = ANGLE_W'(red_ang_ff[RS][l]);
            fld_neg_in[l] = 1'b0;
         end else if (red_ang_ff[RS][l] < R_3QUARTER) begin
            fld_z_in[l] = ANGLE_W'(red_ang_ff[RS][l]) - A_HALF;
            fld_neg_in[l] = 1'b1;
         end else begin
            fld_z_in[l] = ANGLE_W'(red_ang_ff[RS][l]) - A_FULL;
            fld_neg_in[l] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cor_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         cor_vld_ff[0] <= red_vld_ff[RS];
      end
      if (adv) begin
         cor_car_ff[0] <= red_car_ff[RS];
         cor_z_ff[0] <= fld_z_in;
         cor_neg_ff[0] <= fld_neg_in;
         cor_x_ff[0] <= {3{CORDIC_GAIN}};
         cor_y_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_cor
      localparam logic [ANGLE_W-1:0] ATAN = atan_deg(i);
      logic [2:0][TRIG_W-1:0] x_in;
      logic [2:0][TRIG_W-1:0] y_in;
      logic [2:0][ANGLE_W-1:0] z_in;
      always_comb begin
         for (int l = 0; l < 3; l++) begin
            if (!cor_z_ff[i][l][ANGLE_W-1]) begin
               x_in[l] = cor_x_ff[i][l] - TRIG_W'($signed(cor_y_ff[i][l]) >>> i);
               y_in[l] = cor_y_ff[i][l] + TRIG_W'($signed(cor_x_ff[i][l]) >>> i);
               z_in[l] = cor_z_ff[i][l] - ATAN;
            end else begin
               x_in[l] = cor_x_ff[i][l] + TRIG_W'($signed(cor_y_ff[i][l]) >>> i);
               y_in[l] = cor_y_ff[i][l] - TRIG_W'($signed(cor_x_ff[i][l]) >>> i);
               z_in[l] = cor_z_ff[i][l] + ATAN;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            cor_vld_ff[i+1] <= 1'b0;
         end else if (adv) begin
            cor_vld_ff[i+1] <= cor_vld_ff[i];
         end
         if (adv) begin
            cor_car_ff[i+1] <= cor_car_ff[i];
            cor_x_ff[i+1] <= x_in;
            cor_y_ff[i+1] <= y_in;
            cor_z_ff[i+1] <= z_in;
            cor_neg_ff[i+1] <= cor_neg_ff[i];
         end
      end
   end

   // sine and cosine with the fold sign applied
   logic trg_vld_ff;
   carry_type trg_car_ff;
   logic [2:0][TRIG_W-1:0] trg_s_ff;
   logic [2:0][TRIG_W-1:0] trg_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         trg_vld_ff <= 1'b0;
      end else if (adv) begin
         trg_vld_ff <= cor_vld_ff[N];
      end
      if (adv) begin
         trg_car_ff <= cor_car_ff[N];
         for (int l = 0; l < 3; l++) begin
            trg_c_ff[l] <= cor_neg_ff[N][l] ? -cor_x_ff[N][l] : cor_x_ff[N][l];
            trg_s_ff[l] <= cor_neg_ff[N][l] ? -cor_y_ff[N][l] : cor_y_ff[N][l];
         end
      end
   end

   // three plane rotations, multiply stage then round and add stage
   logic [3:0] tin_vld;
   logic tin_op [4];
   logic [2:0][AW-1:0] tin_vec [4];
   logic [2:0][TRIG_W-1:0] tin_s [4];
   logic [2:0][TRIG_W-1:0] tin_c [4];

   assign tin_vld[0] = trg_vld_ff;
   assign tin_op[0] = trg_car_ff.op;
   assign tin_s[0] = trg_s_ff;
   assign tin_c[0] = trg_c_ff;
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         tin_vec[0][l] = AW'($signed(trg_car_ff.vec[l]));
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_turn
      logic mul_vld_ff;
      logic mul_op_ff;
      logic [2:0][AW-1:0] mul_vec_ff;
      logic [2:0][TRIG_W-1:0] mul_s_ff;
      logic [2:0][TRIG_W-1:0] mul_c_ff;
      logic [3:0][PW-1:0] mul_p_ff;
      logic add_vld_ff;
      logic add_op_ff;
      logic [2:0][AW-1:0] add_vec_ff;
      logic [2:0][TRIG_W-1:0] add_s_ff;
      logic [2:0][TRIG_W-1:0] add_c_ff;
      logic [1:0] ia;
      logic [1:0] ib;
      logic [1:0] ig;
      logic [1:0] ja;
      logic [1:0] jb;
      logic signed [AW-1:0] av;
      logic signed [AW-1:0] bv;
      logic signed [TRIG_W-1:0] sv;
      logic signed [TRIG_W-1:0] cv;
      logic [2:0][AW-1:0] vec_in;

      always_comb begin
         ia = turn_a(tin_op[k], k);
         ib = turn_b(tin_op[k], k);
         ig = turn_ang(tin_op[k], k);
         av = $signed(tin_vec[k][ia]);
         bv = $signed(tin_vec[k][ib]);
         cv = $signed(tin_c[k][ig]);
         sv = (tin_op[k] == OP_INVERSE) ? -$signed(tin_s[k][ig]) : $signed(tin_s[k][ig]);
      end

      always_comb begin
         ja = turn_a(mul_op_ff, k);
         jb = turn_b(mul_op_ff, k);
         vec_in = mul_vec_ff;
         vec_in[ja] = round_q30(mul_p_ff[0]) - round_q30(mul_p_ff[1]);
         vec_in[jb] = round_q30(mul_p_ff[2]) + round_q30(mul_p_ff[3]);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            mul_vld_ff <= 1'b0;
            add_vld_ff <= 1'b0;
         end else if (adv) begin
            mul_vld_ff <= tin_vld[k];
            add_vld_ff <= mul_vld_ff;
         end
         if (adv) begin
            mul_op_ff <= tin_op[k];
            mul_vec_ff <= tin_vec[k];
            mul_s_ff <= tin_s[k];
            mul_c_ff <= tin_c[k];
            mul_p_ff[0] <= PW'(PW'(av) * PW'(cv));
            mul_p_ff[1] <= PW'(PW'(bv) * PW'(sv));
            mul_p_ff[2] <= PW'(PW'(av) * PW'(sv));
            mul_p_ff[3] <= PW'(PW'(bv) * PW'(cv));
            add_op_ff <= mul_op_ff;
            add_vec_ff <= vec_in;
            add_s_ff <= mul_s_ff;
            add_c_ff <= mul_c_ff;
         end
      end

      assign tin_vld[k+1] = add_vld_ff;
      assign tin_op[k+1] = add_op_ff;
      assign tin_vec[k+1] = add_vec_ff;
      assign tin_s[k+1] = add_s_ff;
      assign tin_c[k+1] = add_c_ff;
   end

   // saturation and output register
   logic [2:0][VALUE_W-1:0] sat_in;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if ($signed(tin_vec[3][l]) > SAT_MAX) begin
            sat_in[l] = VALUE_W'(SAT_MAX);
         end else if ($signed(tin_vec[3][l]) < SAT_MIN) begin
            sat_in[l] = VALUE_W'(SAT_MIN);
         end else begin
            sat_in[l] = VALUE_W'(tin_vec[3][l]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= tin_vld[3];
      end
      if (adv) begin
         rsp_payload_ff.out_x <= sat_in[0];
         rsp_payload_ff.out_y <= sat_in[1];
         rsp_payload_ff.out_z <= sat_in[2];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
